@@ rtl/hpt_pkg.sv @@
// Shared types and constants for the host presence table.
// Used by hpt_ctrl and new_host_presence_table_core; no dependencies.
package hpt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int MAC_W       = 48;
  localparam int RCNT_W      = 7;

  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [RCNT_W-1:0] COUNT_MAX = {RCNT_W{1'b1}};

  // request command codes
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_SWEEP  = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [MAC_W-1:0] mac;
  } in_t;

  typedef struct packed {
    logic              is_new;
    logic              table_full;
    logic [RCNT_W-1:0] removed_count;
  } out_t;

  // address memory access from the controller
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [MAC_W-1:0] wr_data;
  } ram_req_t;

endpackage

@@ rtl/new_host_presence_table_core.sv @@
// Host presence table top level: controller, address RAM and output register.
// Depends on hpt_pkg, hpt_ram and hpt_ctrl.
//
// Usage:
//   in_valid/in_ready/in_data carry one request: cmd = CMD_REPORT with a
//   48-bit MAC, or cmd = CMD_SWEEP to end a scan round. Each request gives
//   exactly one response on out_valid/out_ready/out_data.
//   A report walks the address RAM one entry per cycle (registered read
//   data) and stops early when the MAC is found. A sweep walks the
//   valid/seen flops one entry per cycle. One request is in work at a time;
//   the next one is taken once the previous response has moved into the
//   output register and the controller is back in idle.
//   The output register decouples the receiver: a new request is accepted
//   while a response waits there. If the receiver stalls, a finished
//   response holds in the controller until the register frees up.
//   Synchronous reset clears all valid and seen bits at once (empty table);
//   the address RAM needs no clearing. in_ready rises as soon as reset ends.
module new_host_presence_table_core
  import hpt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ram_req_t         ram;
  logic [MAC_W-1:0] ram_rd_data;
  logic             res_valid;
  logic             res_ready;
  out_t             res;
  logic             out_valid_r;
  out_t             out_data_r;

  hpt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_valid),
    .req_ready   (in_ready),
    .req         (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram         (ram),
    .ram_rd_data (ram_rd_data)
  );

  hpt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (MAC_W),
    .AW    (IDX_W)
  ) u_addr_ram (
    .clk     (clk),
    .wr_en   (ram.wr_en),
    .wr_addr (ram.wr_addr),
    .wr_data (ram.wr_data),
    .rd_en   (ram.rd_en),
    .rd_addr (ram.rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/hpt_ram.sv @@
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Generic storage, no package dependency.
module hpt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/hpt_ctrl.sv @@
// Table sequencer: walks the address RAM for lookups, keeps valid/seen bits
// in flops and sweeps them one entry per cycle. Depends on hpt_pkg.
module hpt_ctrl
  import hpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  output logic             req_ready,
  input  in_t              req,
  output logic             res_valid,
  input  logic             res_ready,
  output out_t             res,
  output ram_req_t         ram,
  input  logic [MAC_W-1:0] ram_rd_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [MAC_W-1:0]       mac_r, mac_nxt;
  logic [CNT_W-1:0]       issue_r, issue_nxt;
  logic                   cmp_act_r, cmp_act_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   have_free_r, have_free_nxt;
  logic [IDX_W-1:0]       free_r, free_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [TABLE_DEPTH-1:0] seen_r, seen_nxt;
  logic [RCNT_W-1:0]      cnt_r, cnt_nxt;
  out_t                   res_r, res_nxt;

  logic             done;
  logic [IDX_W-1:0] idx;
  logic             hit;

  assign done = (issue_r == DEPTH_CNT);
  assign idx  = issue_r[IDX_W-1:0];
  assign hit  = cmp_act_r && valid_r[cmp_idx_r] && (ram_rd_data == mac_r);

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    mac_nxt       = mac_r;
    issue_nxt     = issue_r;
    cmp_act_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    have_free_nxt = have_free_r;
    free_nxt      = free_r;
    valid_nxt     = valid_r;
    seen_nxt      = seen_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    ram           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          mac_nxt       = req.mac;
          issue_nxt     = '0;
          have_free_nxt = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = (req.cmd == CMD_SWEEP) ? ST_SWEEP : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, compare the one returned
        if (!done) begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = idx;
          issue_nxt   = issue_r + CNT_W'(1);
          cmp_act_nxt = 1'b1;
          cmp_idx_nxt = idx;
        end
        if (hit) begin
          seen_nxt[cmp_idx_r] = 1'b1;
          res_nxt             = '0;
          cmp_act_nxt         = 1'b0;
          state_nxt           = ST_RESULT;
        end else begin
          if (cmp_act_r && !valid_r[cmp_idx_r] && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = cmp_idx_r;
          end
          // all entries compared: insert at lowest free slot or flag full
          if (done && !cmp_act_r) begin
            res_nxt = '0;
            if (have_free_r) begin
              ram.wr_en         = 1'b1;
              ram.wr_addr       = free_r;
              ram.wr_data       = mac_r;
              valid_nxt[free_r] = 1'b1;
              seen_nxt[free_r]  = 1'b1;
              res_nxt.is_new    = 1'b1;
            end else begin
              res_nxt.table_full = 1'b1;
            end
            state_nxt = ST_RESULT;
          end
        end
      end

      ST_SWEEP: begin
        // one entry per cycle: drop unseen, clear marks of the rest
        if (done) begin
          res_nxt               = '0;
          res_nxt.removed_count = cnt_r;
          state_nxt             = ST_RESULT;
        end else begin
          if (valid_r[idx]) begin
            if (seen_r[idx]) begin
              seen_nxt[idx] = 1'b0;
            end else begin
              valid_nxt[idx] = 1'b0;
              if (cnt_r != COUNT_MAX) begin
                cnt_nxt = cnt_r + RCNT_W'(1);
              end
            end
          end
          issue_nxt = issue_r + CNT_W'(1);
        end
      end

      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, working and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mac_r       <= '0;
      issue_r     <= '0;
      cmp_act_r   <= 1'b0;
      cmp_idx_r   <= '0;
      have_free_r <= 1'b0;
      free_r      <= '0;
      valid_r     <= '0;
      seen_r      <= '0;
      cnt_r       <= '0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mac_r       <= mac_nxt;
      issue_r     <= issue_nxt;
      cmp_act_r   <= cmp_act_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      have_free_r <= have_free_nxt;
      free_r      <= free_nxt;
      valid_r     <= valid_nxt;
      seen_r      <= seen_nxt;
      cnt_r       <= cnt_nxt;
      res_r       <= res_nxt;
    end
  end

  // no request is taken while reset is held
  assign req_ready = rst_n && (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESULT);
  assign res       = res_r;

endmodule

@@ sim/tb_new_host_presence_table_core.sv @@
// Testbench for new_host_presence_table_core: report and sweep requests with
// a predicting scoreboard that checks every response field in order.
// Depends on hpt_pkg and the host presence table RTL.
module tb_new_host_presence_table_core;
  import hpt_pkg::*;

  localparam int POOL_SIZE    = 32;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int STUCK_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_mode_t;

  // Host table predictor plus queue of expected responses
  class host_table_scoreboard;
    logic [MAC_W-1:0] host_mac [TABLE_DEPTH];
    bit               occupied [TABLE_DEPTH];
    bit               seen_mark [TABLE_DEPTH];
    out_t             expected_q [$];
    int               errors;
    int               results_checked;

    function out_t predict_response(in_t req);
      out_t rsp;
      int   free_idx;
      int   dropped;
      bit   hit;
      rsp      = '0;
      free_idx = -1;
      dropped  = 0;
      hit      = 1'b0;
      if (req.cmd == CMD_REPORT) begin
        // look for the MAC, remember the lowest free slot on the way
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (occupied[k]) begin
            if (!hit && host_mac[k] == req.mac) begin
              seen_mark[k] = 1'b1;
              hit          = 1'b1;
            end
          end else if (free_idx < 0) begin
            free_idx = k;
          end
        end
        if (!hit) begin
          if (free_idx >= 0) begin
            host_mac[free_idx]  = req.mac;
            occupied[free_idx]  = 1'b1;
            seen_mark[free_idx] = 1'b1;
            rsp.is_new          = 1'b1;
          end else begin
            rsp.table_full = 1'b1;
          end
        end
      end else begin
        // end of round: drop unseen hosts, clear marks on the rest
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (occupied[k]) begin
            if (seen_mark[k]) begin
              seen_mark[k] = 1'b0;
            end else begin
              occupied[k] = 1'b0;
              dropped++;
            end
          end
        end
        rsp.removed_count = (dropped > int'(COUNT_MAX)) ? COUNT_MAX : RCNT_W'(dropped);
      end
      return rsp;
    endfunction

    function void note_request(in_t req);
      expected_q.push_back(predict_response(req));
    endfunction

    function void check_response(out_t got);
      out_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.is_new !== want.is_new) begin
        $display("%0t: is_new mismatch, expected %0b, actual %0b",
                 $time, want.is_new, got.is_new);
        errors++;
      end
      if (got.table_full !== want.table_full) begin
        $display("%0t: table_full mismatch, expected %0b, actual %0b",
                 $time, want.table_full, got.table_full);
        errors++;
      end
      if (got.removed_count !== want.removed_count) begin
        $display("%0t: removed_count mismatch, expected %0d, actual %0d",
                 $time, want.removed_count, got.removed_count);
        errors++;
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  in_t  in_data   = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  host_table_scoreboard sb = new();

  logic [MAC_W-1:0] mac_pool [POOL_SIZE];
  int burst_left   = 0;
  int items_sent   = 0;
  int stuck_cycles = 0;

  new_host_presence_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [MAC_W-1:0] fresh_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MAC_W-1:0];
  endfunction

  // random MAC with some weight on corner patterns
  function automatic logic [MAC_W-1:0] any_mac();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return MAC_W'(1) << $urandom_range(0, MAC_W - 1);
      default: return fresh_mac();
    endcase
  endfunction

  // Send one request, then either continue the burst or idle for a gap
  task automatic issue(input logic cmd, input logic [MAC_W-1:0] mac);
    in_t req;
    int  gap;
    req.cmd  = cmd;
    req.mac  = mac;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Empty the table, overfill it, touch known hosts, then age them all out
  task automatic flood_round();
    logic [MAC_W-1:0] stored_q [$];
    logic [MAC_W-1:0] m;
    issue(CMD_SWEEP, fresh_mac());
    issue(CMD_SWEEP, fresh_mac());
    repeat (TABLE_DEPTH + $urandom_range(1, 4)) begin
      m = fresh_mac();
      stored_q.push_back(m);
      issue(CMD_REPORT, m);
    end
    repeat ($urandom_range(2, 5)) issue(CMD_REPORT, stored_q[$urandom_range(0, TABLE_DEPTH - 1)]);
    issue(CMD_REPORT, stored_q[TABLE_DEPTH]);
    issue(CMD_SWEEP, fresh_mac());
    issue(CMD_SWEEP, fresh_mac());
  endtask

  // One scan round of reports drawn from a host pool, closed by a sweep
  task automatic pool_round();
    int active;
    int len;
    active = $urandom_range(1, POOL_SIZE);
    len    = $urandom_range(4, 40);
    for (int k = 0; k < POOL_SIZE; k++) begin
      if ($urandom_range(0, 3) == 0) mac_pool[k] = any_mac();
    end
    repeat (len) begin
      case ($urandom_range(0, 19))
        0:       issue(CMD_SWEEP, any_mac());
        1, 2:    issue(CMD_REPORT, any_mac());
        default: issue(CMD_REPORT, mac_pool[$urandom_range(0, active - 1)]);
      endcase
    end
    issue(CMD_SWEEP, any_mac());
  endtask

  // Stimulus and end of run
  initial begin
    for (int k = 0; k < POOL_SIZE; k++) mac_pool[k] = any_mac();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corners of the MAC field, known hosts, sweeps with junk mac
    issue(CMD_SWEEP, '1);
    issue(CMD_REPORT, '0);
    issue(CMD_REPORT, '1);
    issue(CMD_REPORT, '0);
    issue(CMD_REPORT, 48'h0000_0000_0001);
    issue(CMD_REPORT, 48'h8000_0000_0000);
    issue(CMD_SWEEP, 48'h1234_5678_9ABC);
    issue(CMD_REPORT, '1);
    issue(CMD_SWEEP, '0);
    issue(CMD_REPORT, '0);
    issue(CMD_REPORT, 48'h5555_5555_5555);
    issue(CMD_REPORT, 48'hAAAA_AAAA_AAAA);
    issue(CMD_REPORT, 48'h0000_0000_0001);
    issue(CMD_SWEEP, '1);
    issue(CMD_SWEEP, 48'hAAAA_AAAA_AAAA);
    issue(CMD_REPORT, 48'h5555_5555_5555);

    // random rounds; the first one always fills the table
    flood_round();
    while (items_sent < RANDOM_ITEMS + 16) begin
      if ($urandom_range(0, 5) == 0) flood_round();
      else pool_round();
    end
    if (in_valid) in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: stall patterns of varying density, plus one long hold-off
  initial begin
    stall_mode_t mode;
    int          len;
    bit          hold_done;
    hold_done = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      len  = $urandom_range(10, 150);
      repeat (len) begin
        if (!hold_done && sb.results_checked >= 60) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          STALL_NONE:  out_ready <= 1'b1;
          STALL_HALF:  out_ready <= $urandom_range(0, 1);
          STALL_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
          default:     out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Response checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_response(out_data);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
